/* src/pulse_channel_with_sweep_core_assert.svh */
// assertion macros for the pulse channel core
`ifndef PULSE_CHANNEL_WITH_SWEEP_CORE_ASSERT_SVH
`define PULSE_CHANNEL_WITH_SWEEP_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PCS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCS_ASSERT_ALWAYS(lbl, expr, msg)
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/pcs_pkg.sv */
`timescale 1ns / 1ps

package pcs_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_STEP  = 2'd3
  } op_t;

  localparam logic [2:0] REG_SWEEP  = 3'd0;
  localparam logic [2:0] REG_DUTY   = 3'd1;
  localparam logic [2:0] REG_ENV    = 3'd2;
  localparam logic [2:0] REG_LOW    = 3'd3;
  localparam logic [2:0] REG_HIGH   = 3'd4;

  localparam int          LENGTH_LIMIT_DEF = 63;
  localparam logic [31:0] DUTY_RESET       = 32'h7E87_8101;
  localparam logic [11:0] PERIOD_SPAN      = 12'h800;
  localparam logic [3:0]  VOLUME_MAX       = 4'hF;

  typedef struct packed {
    op_t        op;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample_level;
    logic       channel_on;
  } out_beat_t;

endpackage

/* src/pcs_in_stage.sv */
`timescale 1ns / 1ps

`include "pulse_channel_with_sweep_core_assert.svh"

module pcs_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcs_pkg::in_beat_t in_data,
  input  logic             out_free,
  output logic             fire,
  output pcs_pkg::in_beat_t item
);
  import pcs_pkg::*;

  logic     in_valid_r;
  in_beat_t in_data_r;

  assign fire     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || fire;
  assign item     = in_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  `PCS_ASSERT_NEXT(a_in_hold, in_valid_r && !fire, in_valid_r && $stable(in_data_r), "held beat lost")
  `PCS_ASSERT_ALWAYS(a_fire_valid, !fire || in_valid_r, "fire without a beat")

endmodule

/* src/pcs_chan.sv */
`timescale 1ns / 1ps

`include "pulse_channel_with_sweep_core_assert.svh"

module pcs_chan #(
  parameter int LENGTH_LIMIT = pcs_pkg::LENGTH_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              fire,
  input  pcs_pkg::in_beat_t item,
  output pcs_pkg::out_beat_t result
);
  import pcs_pkg::*;

  localparam logic [7:0] LEN_MAX  = 8'(LENGTH_LIMIT);
  // a reload takes six bits of register 1, so the count can sit at 63
  localparam logic [7:0] LEN_CEIL = 8'((LENGTH_LIMIT >= 63) ? LENGTH_LIMIT + 1 : 63);

  logic [31:0] duty_r;
  logic [7:0]  sweep_r, sweep_nxt, dl_r, dl_nxt, env_r, env_nxt;
  logic [7:0]  low_r, low_nxt, high_r, high_nxt;
  logic        enabled_r, enabled_nxt, dac_r, dac_nxt, sw_act_r, sw_act_nxt;
  logic [3:0]  vol_r, vol_nxt, level_r, level_nxt;
  logic [2:0]  env_cnt_r, env_cnt_nxt, pos_r, pos_nxt, step_r, step_nxt;
  logic [7:0]  len_r, len_nxt, sw_cd_r, sw_cd_nxt;
  logic [11:0] cd_r, cd_nxt;
  logic [10:0] shadow_r, shadow_nxt;

  function automatic logic [11:0] sweep_next(logic [10:0] shadow, logic [7:0] sw);
    logic [10:0] delta;
    delta = shadow >> sw[2:0];
    if (sw[3]) begin
      sweep_next = {1'b0, shadow} - {1'b0, delta};
    end else begin
      sweep_next = {1'b0, shadow} + {1'b0, delta};
    end
  endfunction

  always_comb begin
    logic [7:0]  d;
    logic [7:0]  rd;
    logic [10:0] period;
    logic [11:0] calc1;
    logic [11:0] calc2;
    logic [3:0]  ecnt;
    logic [7:0]  cd;
    logic [2:0]  step;

    d           = item.write_data;
    rd          = 8'd0;
    period      = {high_r[2:0], low_r};
    calc1       = 12'd0;
    calc2       = 12'd0;
    ecnt        = 4'd0;
    cd          = 8'd0;
    step        = step_r + 3'd1;
    sweep_nxt   = sweep_r;
    dl_nxt      = dl_r;
    env_nxt     = env_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    enabled_nxt = enabled_r;
    dac_nxt     = dac_r;
    sw_act_nxt  = sw_act_r;
    vol_nxt     = vol_r;
    level_nxt   = level_r;
    env_cnt_nxt = env_cnt_r;
    pos_nxt     = pos_r;
    step_nxt    = step_r;
    len_nxt     = len_r;
    sw_cd_nxt   = sw_cd_r;
    cd_nxt      = cd_r;
    shadow_nxt  = shadow_r;

    case (item.op)
      OP_WRITE: begin
        case (item.reg_index)
          REG_SWEEP: begin
            if (d[6:4] != 3'd0 && sweep_r[6:4] == 3'd0) begin
              sw_cd_nxt = {5'd0, d[6:4]};
            end
            sweep_nxt = d;
          end
          REG_DUTY: dl_nxt = d;
          REG_ENV: begin
            env_nxt = d;
            dac_nxt = (d[7:3] != 5'd0);
            if (d[7:3] == 5'd0) begin
              enabled_nxt = 1'b0;
              level_nxt   = 4'd0;
            end
          end
          REG_LOW: low_nxt = d;
          REG_HIGH: begin
            high_nxt = d;
            if (d[7]) begin
              period      = {d[2:0], low_r};
              enabled_nxt = dac_r;
              vol_nxt     = env_r[7:4];
              if (len_r > LEN_MAX) begin
                len_nxt = {2'd0, dl_r[5:0]};
              end
              env_cnt_nxt = 3'd0;
              shadow_nxt  = period;
              sw_act_nxt  = (sweep_r[6:4] != 3'd0) || (sweep_r[2:0] != 3'd0);
              calc1       = sweep_next(period, sweep_r);
              if (sweep_r[2:0] != 3'd0 && calc1[11]) begin
                enabled_nxt = 1'b0;
                level_nxt   = 4'd0;
              end
              sw_cd_nxt = {5'd0, sweep_r[6:4]};
              if (enabled_nxt) begin
                cd_nxt = PERIOD_SPAN - {1'b0, period};
              end
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (item.reg_index)
          REG_SWEEP: rd = sweep_r;
          REG_DUTY:  rd = dl_r;
          REG_ENV:   rd = env_r;
          REG_LOW:   rd = low_r;
          REG_HIGH:  rd = high_r;
          default:   rd = 8'd0;
        endcase
      end
      OP_TICK: begin
        if (enabled_r) begin
          if (cd_r <= 12'd1) begin
            level_nxt = duty_r[{dl_r[7:6], ~pos_r}] ? vol_r : 4'd0;
            pos_nxt   = pos_r + 3'd1;
            cd_nxt    = PERIOD_SPAN - {1'b0, period};
          end else begin
            cd_nxt = cd_r - 12'd1;
          end
        end
      end
      default: begin
        step_nxt = step;
        // length counter
        if (!step[0]) begin
          if (high_r[6] && len_r <= LEN_MAX) begin
            len_nxt = len_r + 8'd1;
          end
          if (len_nxt > LEN_MAX) begin
            enabled_nxt = 1'b0;
            level_nxt   = 4'd0;
          end
        end
        // sweep
        if ((step == 3'd2 || step == 3'd6) && sw_act_r && sweep_r[6:4] != 3'd0) begin
          cd = sw_cd_r - 8'd1;
          sw_cd_nxt = cd;
          if (cd == 8'd0) begin
            sw_cd_nxt = {5'd0, sweep_r[6:4]};
            calc1     = sweep_next(shadow_r, sweep_r);
            if (calc1[11]) begin
              enabled_nxt = 1'b0;
              level_nxt   = 4'd0;
            end else if (sweep_r[2:0] != 3'd0) begin
              shadow_nxt = calc1[10:0];
              low_nxt    = calc1[7:0];
              high_nxt   = {high_r[7:3], calc1[10:8]};
            end
            calc2 = sweep_next(shadow_nxt, sweep_r);
            if (calc2[11]) begin
              enabled_nxt = 1'b0;
              level_nxt   = 4'd0;
            end
          end
        end
        // envelope
        if (step == 3'd7 && env_r[2:0] != 3'd0) begin
          ecnt = {1'b0, env_cnt_r} + 4'd1;
          if (ecnt >= {1'b0, env_r[2:0]}) begin
            ecnt = 4'd0;
            if (!env_r[3]) begin
              if (vol_r != 4'd0) vol_nxt = vol_r - 4'd1;
            end else begin
              if (vol_r != VOLUME_MAX) vol_nxt = vol_r + 4'd1;
            end
          end
          env_cnt_nxt = ecnt[2:0];
        end
      end
    endcase

    result.read_data    = rd;
    result.sample_level = enabled_nxt ? level_nxt : 4'd0;
    result.channel_on   = enabled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= DUTY_RESET;
    end else if (cfg_we) begin
      duty_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= 8'd0;
      dl_r      <= 8'd0;
      env_r     <= 8'd0;
      low_r     <= 8'd0;
      high_r    <= 8'd0;
      enabled_r <= 1'b0;
      dac_r     <= 1'b0;
      sw_act_r  <= 1'b0;
      vol_r     <= 4'd0;
      level_r   <= 4'd0;
      env_cnt_r <= 3'd0;
      pos_r     <= 3'd0;
      step_r    <= 3'd0;
      len_r     <= LEN_MAX + 8'd1;
      sw_cd_r   <= 8'd0;
      cd_r      <= 12'd0;
      shadow_r  <= 11'd0;
    end else if (fire) begin
      sweep_r   <= sweep_nxt;
      dl_r      <= dl_nxt;
      env_r     <= env_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      enabled_r <= enabled_nxt;
      dac_r     <= dac_nxt;
      sw_act_r  <= sw_act_nxt;
      vol_r     <= vol_nxt;
      level_r   <= level_nxt;
      env_cnt_r <= env_cnt_nxt;
      pos_r     <= pos_nxt;
      step_r    <= step_nxt;
      len_r     <= len_nxt;
      sw_cd_r   <= sw_cd_nxt;
      cd_r      <= cd_nxt;
      shadow_r  <= shadow_nxt;
    end
  end

  `PCS_ASSERT_ALWAYS(a_en_dac, !enabled_r || dac_r, "channel on with dac off")
  `PCS_ASSERT_ALWAYS(a_len_sat, len_r <= LEN_CEIL, "length count past saturation")
  `PCS_ASSERT_ALWAYS(a_cd_range, cd_r <= PERIOD_SPAN, "period countdown out of range")

endmodule

/* src/pcs_out_stage.sv */
`timescale 1ns / 1ps

`include "pulse_channel_with_sweep_core_assert.svh"

module pcs_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  pcs_pkg::out_beat_t result,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output pcs_pkg::out_beat_t out_data
);
  import pcs_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  `PCS_ASSERT_NEXT(a_fire_shows, fire, out_valid_r, "result beat not presented")

endmodule

/* src/pulse_channel_with_sweep_core.sv */
`timescale 1ns / 1ps

// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | in_data   (op, reg_index, write_data)
// out     | out_valid | out_ready | out_data  (read_data, sample_level, channel_on)
// cfg     | cfg_valid | cfg_ready | cfg_data  (duty patterns)
//
// one beat per cycle unless out_ready stalls; result is registered after the input register
// the whole channel update is one combinational pass from input register to result register
// synchronous active-low reset; no clearing pass, cfg_ready is always high
// a stalled output holds one result while one more input beat waits in the input register

module pulse_channel_with_sweep_core #(
  parameter int LENGTH_LIMIT = pcs_pkg::LENGTH_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcs_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import pcs_pkg::*;

  logic      fire;
  logic      out_free;
  in_beat_t  item;
  out_beat_t result;

  assign cfg_ready = 1'b1;

  pcs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .fire     (fire),
    .item     (item)
  );

  pcs_chan #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  pcs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
